@@ rtl/dsf_pkg.sv @@
// ----------------------------------------------------------------------------
// dsf_pkg: shared types and constants of the disk image sector finder
// Defines the queued word format, the parser phases and the ID header layout.
// ----------------------------------------------------------------------------
package dsf_pkg;

    // ID header layout
    localparam logic [3:0] HDR_COUNT_LO = 4'h4;
    localparam logic [3:0] HDR_COUNT_HI = 4'h5;
    localparam logic [3:0] HDR_LEN_LO   = 4'he;
    localparam logic [3:0] HDR_LAST     = 4'hf;

    // Queue between front and back
    localparam int unsigned QDepth = 4;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = $clog2(QDepth + 1);

    typedef enum logic [0:0] {
        K_START = 1'b0,
        K_BYTE  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] chrn;
        logic [15:0] limit;
        logic [7:0]  data;
    } t_word;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic  vld;
        t_word word;
    } t_q_head;

    // Queue status, visible to the top level
    typedef struct packed {
        logic [QCntW-1:0] count;
        logic             full;
    } t_q_stat;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_SEND   = 4'b0100,
        PH_SKIP   = 4'b1000
    } t_phase;

endpackage

@@ rtl/disk_image_sector_finder.sv @@
// ----------------------------------------------------------------------------
// disk_image_sector_finder: sector read from one track of a disk image
// Takes a C/H/R/N request, parses the track's ID headers and returns the
// data bytes of the matching sector, or a single status result if it is absent or empty.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Word
//  --------+-----------+-------------------------+-----------------------------
//  in      | to block  | i_in_valid / o_in_stall | start request or track byte
//  out     | from block| o_out_valid / i_out_stall| data byte or final status
//
//  One word per cycle on the input channel while the queue is not full; the
//  parser in the back end handles one queued word each cycle unless a result is held by i_out_stall.
//  A word passes through the 4-deep queue; its result goes to the result register.
//  Reset empties the queue, drops any pending result and parks the parser
//  in idle; bytes seen while idle are dropped.
//  o_in_stall rises only when the queue is full; the back end holds while a
//  result waits in the output register under i_out_stall.
//
module disk_image_sector_finder import dsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_want_cyl,
    input  logic [7:0]  i_want_head,
    input  logic [7:0]  i_want_rec,
    input  logic [7:0]  i_want_size_code,
    input  logic [15:0] i_buf_limit,
    input  logic [7:0]  i_track_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_data,
    output logic [7:0]  o_data_out,
    output logic        o_found,
    output logic        o_done_res,
    output logic [15:0] o_read_length
);

    t_q_head q_head;
    t_q_stat q_stat;
    logic    q_pop;

    // Front: classify each word and queue it
    dsf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_cmd            (i_cmd),
        .i_want_cyl       (i_want_cyl),
        .i_want_head      (i_want_head),
        .i_want_rec       (i_want_rec),
        .i_want_size_code (i_want_size_code),
        .i_buf_limit      (i_buf_limit),
        .i_track_byte     (i_track_byte),
        .i_pop            (q_pop),
        .o_head           (q_head),
        .o_stat           (q_stat)
    );

    // Back: parse headers, send or skip data, register results
    dsf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_is_data     (o_is_data),
        .o_data_out    (o_data_out),
        .o_found       (o_found),
        .o_done_res    (o_done_res),
        .o_read_length (o_read_length)
    );

    // Queue occupancy stays within its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= QCntW'(QDepth))
        else $error("queue count beyond depth");

    // Never pop an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_stat.count != '0)
        else $error("pop from empty queue");

    // Data bytes come only from a found sector
    a_data_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_data |-> o_found)
        else $error("data byte without match");

    // A status-only result always ends the request
    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_data |-> o_done_res && o_read_length == 16'd0)
        else $error("status result not final");

    // Length is reported only on the final result
    a_len_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_done_res |-> o_read_length == 16'd0)
        else $error("length on non-final result");

endmodule

@@ rtl/dsf_front.sv @@
// ----------------------------------------------------------------------------
// dsf_front: input stage of the sector finder
// Classifies each accepted word as start or track byte and queues it.
// ----------------------------------------------------------------------------
module dsf_front import dsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_want_cyl,
    input  logic [7:0]  i_want_head,
    input  logic [7:0]  i_want_rec,
    input  logic [7:0]  i_want_size_code,
    input  logic [15:0] i_buf_limit,
    input  logic [7:0]  i_track_byte,
    input  logic        i_pop,
    output t_q_head     o_head,
    output t_q_stat     o_stat
);

    t_word            r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QCntW-1:0] r_count;
    logic [QCntW-1:0] n_count;
    logic             full;
    logic             push;
    logic             pop;
    t_word            in_word;

    assign full = (r_count == QCntW'(QDepth));
    assign push = i_valid && !full;
    assign pop  = i_pop && (r_count != '0);

    always_comb begin
        in_word.kind  = i_cmd ? K_BYTE : K_START;
        in_word.chrn  = {i_want_size_code, i_want_rec, i_want_head, i_want_cyl};
        in_word.limit = i_buf_limit;
        in_word.data  = i_track_byte;
    end

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_stall      = full;
    assign o_head.vld   = (r_count != '0);
    assign o_head.word  = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.full  = full;

endmodule

@@ rtl/dsf_back.sv @@
// ----------------------------------------------------------------------------
// dsf_back: track parser and result register of the sector finder
// Walks ID headers, sends or skips sector data, and registers each result.
// ----------------------------------------------------------------------------
module dsf_back import dsf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_head     i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_data,
    output logic [7:0]  o_data_out,
    output logic        o_found,
    output logic        o_done_res,
    output logic [15:0] o_read_length
);

    t_phase      r_phase,        n_phase;
    logic [3:0]  r_header_pos,   n_header_pos;
    logic [31:0] r_wanted_chrn,  n_wanted_chrn;
    logic [31:0] r_seen_chrn,    n_seen_chrn;
    logic [15:0] r_byte_limit,   n_byte_limit;
    logic [15:0] r_sector_total, n_sector_total;
    logic [15:0] r_sector_index, n_sector_index;
    logic [15:0] r_data_length,  n_data_length;
    logic [15:0] r_bytes_left,   n_bytes_left;
    logic [15:0] r_bytes_sent,   n_bytes_sent;

    logic        r_out_valid;
    logic        r_is_data;
    logic [7:0]  r_data_out;
    logic        r_found;
    logic        r_done_res;
    logic [15:0] r_read_length;

    logic        take;
    logic        res_vld;
    logic        res_is_data;
    logic [7:0]  res_data;
    logic        res_found;
    logic        res_done;
    logic [15:0] res_len;
    logic [15:0] send_len;
    logic [7:0]  b;

    assign take = i_head.vld && (!r_out_valid || !i_stall);
    assign b    = i_head.word.data;

    always_comb begin
        n_phase        = r_phase;
        n_header_pos   = r_header_pos;
        n_wanted_chrn  = r_wanted_chrn;
        n_seen_chrn    = r_seen_chrn;
        n_byte_limit   = r_byte_limit;
        n_sector_total = r_sector_total;
        n_sector_index = r_sector_index;
        n_data_length  = r_data_length;
        n_bytes_left   = r_bytes_left;
        n_bytes_sent   = r_bytes_sent;
        res_vld        = 1'b0;
        res_is_data    = 1'b0;
        res_data       = '0;
        res_found      = 1'b0;
        res_done       = 1'b0;
        res_len        = '0;
        send_len       = '0;

        if (take) begin
            if (i_head.word.kind == K_START) begin
                n_wanted_chrn  = i_head.word.chrn;
                n_byte_limit   = i_head.word.limit;
                n_sector_index = '0;
                n_bytes_left   = '0;
                n_bytes_sent   = '0;
                n_phase        = PH_HEADER;
                n_header_pos   = '0;
                n_seen_chrn    = '0;
                n_sector_total = '0;
                n_data_length  = '0;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_header_pos < HDR_COUNT_LO) begin
                            n_seen_chrn[{r_header_pos[1:0], 3'b000} +: 8] = b;
                        end else if (r_header_pos == HDR_COUNT_LO) begin
                            n_sector_total[7:0] = b;
                        end else if (r_header_pos == HDR_COUNT_HI) begin
                            n_sector_total[15:8] = b;
                        end else if (r_header_pos == HDR_LEN_LO) begin
                            n_data_length[7:0] = b;
                        end else if (r_header_pos == HDR_LAST) begin
                            n_data_length[15:8] = b;
                        end
                        send_len = (n_data_length < r_byte_limit) ? n_data_length
                                                                  : r_byte_limit;
                        if (r_header_pos != HDR_LAST) begin
                            n_header_pos = r_header_pos + 1'b1;
                        end else begin
                            n_header_pos = '0;
                            if (n_sector_total == '0) begin
                                // empty track: not found
                                n_phase  = PH_IDLE;
                                res_vld  = 1'b1;
                                res_done = 1'b1;
                            end else if (n_seen_chrn == r_wanted_chrn) begin
                                n_bytes_sent = '0;
                                if (send_len == '0) begin
                                    n_phase   = PH_IDLE;
                                    res_vld   = 1'b1;
                                    res_found = 1'b1;
                                    res_done  = 1'b1;
                                end else begin
                                    n_bytes_left = send_len;
                                    n_phase      = PH_SEND;
                                end
                            end else if (r_sector_index == n_sector_total - 1'b1) begin
                                // last sector did not match
                                n_phase  = PH_IDLE;
                                res_vld  = 1'b1;
                                res_done = 1'b1;
                            end else begin
                                n_sector_index = r_sector_index + 1'b1;
                                if (n_data_length == '0) begin
                                    n_phase        = PH_HEADER;
                                    n_seen_chrn    = '0;
                                    n_sector_total = '0;
                                    n_data_length  = '0;
                                end else begin
                                    n_bytes_left = n_data_length;
                                    n_phase      = PH_SKIP;
                                end
                            end
                        end
                    end
                    PH_SEND: begin
                        n_bytes_sent = r_bytes_sent + 1'b1;
                        n_bytes_left = r_bytes_left - 1'b1;
                        res_vld      = 1'b1;
                        res_is_data  = 1'b1;
                        res_data     = b;
                        res_found    = 1'b1;
                        if (n_bytes_left == '0) begin
                            n_phase  = PH_IDLE;
                            res_done = 1'b1;
                            res_len  = n_bytes_sent;
                        end
                    end
                    PH_SKIP: begin
                        n_bytes_left = r_bytes_left - 1'b1;
                        if (n_bytes_left == '0) begin
                            n_phase        = PH_HEADER;
                            n_header_pos   = '0;
                            n_seen_chrn    = '0;
                            n_sector_total = '0;
                            n_data_length  = '0;
                        end
                    end
                    default: begin
                        // idle: drop the byte
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_header_pos   <= '0;
            r_wanted_chrn  <= '0;
            r_seen_chrn    <= '0;
            r_byte_limit   <= '0;
            r_sector_total <= '0;
            r_sector_index <= '0;
            r_data_length  <= '0;
            r_bytes_left   <= '0;
            r_bytes_sent   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_header_pos   <= n_header_pos;
            r_wanted_chrn  <= n_wanted_chrn;
            r_seen_chrn    <= n_seen_chrn;
            r_byte_limit   <= n_byte_limit;
            r_sector_total <= n_sector_total;
            r_sector_index <= n_sector_index;
            r_data_length  <= n_data_length;
            r_bytes_left   <= n_bytes_left;
            r_bytes_sent   <= n_bytes_sent;
            if (!r_out_valid || !i_stall) begin
                r_out_valid <= take && res_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res_vld) begin
            r_is_data     <= res_is_data;
            r_data_out    <= res_data;
            r_found       <= res_found;
            r_done_res    <= res_done;
            r_read_length <= res_len;
        end
    end

    assign o_pop         = take;
    assign o_valid       = r_out_valid;
    assign o_is_data     = r_is_data;
    assign o_data_out    = r_data_out;
    assign o_found       = r_found;
    assign o_done_res    = r_done_res;
    assign o_read_length = r_read_length;

endmodule
